[hw/rtl/hpb_pkg.sv]
// Package for the pixel histogram block: sizes, codes and the types that
// travel between the front end, the bin engine and the top level. No dependencies.
`default_nettype none

package hpb_pkg;

    localparam int BIN_INDEX_BITS = 16;
    localparam int COUNT_BITS     = 32;
    localparam int BAR_BITS       = 8;
    localparam int PROD_BITS      = COUNT_BITS + BAR_BITS;
    localparam int STEP_BITS      = $clog2(BAR_BITS);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] FMT_GRAY8  = 2'd0;
    localparam logic [1:0] FMT_GRAY16 = 2'd1;
    localparam logic [1:0] FMT_RGB    = 2'd2;

    localparam logic [1:0] CH_BYTE0 = 2'd0;
    localparam logic [1:0] CH_BYTE1 = 2'd1;
    localparam logic [1:0] CH_BYTE2 = 2'd2;

    localparam logic [1:0] REG_PIXEL_FORMAT   = 2'd0;
    localparam logic [1:0] REG_CHANNEL_SELECT = 2'd1;
    localparam logic [1:0] REG_BAR_SCALE      = 2'd2;

    localparam logic [BAR_BITS-1:0] BAR_SCALE_RESET = 8'd50;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [BIN_INDEX_BITS-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0]          pixel_format;
        logic [1:0]          channel_select;
        logic [BAR_BITS-1:0] bar_scale;
    } t_cfg;

    typedef struct packed {
        logic init;
    } t_back_stat;

endpackage

`default_nettype wire

[hw/rtl/hpb_front.sv]
// Front end: accepts input beats, maps each to a bin command and queues those that are valid.
// Depends on hpb_pkg.
`default_nettype none

module hpb_front
    import hpb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_hold,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_action,
    input  wire logic [23:0] i_sample,
    input  wire logic [15:0] i_bin_index,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_pop
);

    t_cmd                 r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    t_cmd                 w_cmd;
    logic                 w_keep;
    logic                 w_enq;
    logic                 w_deq;
    logic [7:0]           w_byte;

    always_comb begin
        w_keep  = 1'b0;
        w_cmd   = '{op: OP_SAMPLE, idx: '0};
        case (i_cfg.channel_select)
            CH_BYTE1: w_byte = i_sample[15:8];
            CH_BYTE2: w_byte = i_sample[23:16];
            default:  w_byte = i_sample[7:0];
        endcase
        unique case (i_action)
            ACT_SAMPLE: begin
                w_cmd.op = OP_SAMPLE;
                unique case (i_cfg.pixel_format)
                    FMT_GRAY8: begin
                        w_cmd.idx = BIN_INDEX_BITS'(i_sample[7:0]);
                        w_keep    = 1'b1;
                    end
                    FMT_GRAY16: begin
                        w_cmd.idx = i_sample[BIN_INDEX_BITS-1:0];
                        w_keep    = 1'b1;
                    end
                    FMT_RGB: begin
                        w_cmd.idx = BIN_INDEX_BITS'(w_byte);
                        w_keep    = (i_cfg.channel_select <= CH_BYTE2);
                    end
                    default: w_keep = 1'b0;
                endcase
            end
            ACT_READ: begin
                w_cmd.op  = OP_READ;
                w_cmd.idx = i_bin_index[BIN_INDEX_BITS-1:0];
                w_keep    = 1'b1;
            end
            ACT_CLEAR: begin
                w_cmd.op = OP_CLEAR;
                w_keep   = 1'b1;
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign full        = i_hold || (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign w_enq       = push && !full && w_keep;
    assign o_cmd_valid = (r_count != '0);
    assign w_deq       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_deq) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_enq && !w_deq) begin
                r_count <= r_count + 1'b1;
            end else if (!w_enq && w_deq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hpb_div.sv]
// Restoring divider that yields the bar length one quotient bit per cycle.
// Depends on hpb_pkg.
`default_nettype none

module hpb_div
    import hpb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [PROD_BITS-1:0]  i_dividend,
    input  wire logic [COUNT_BITS-1:0] i_divisor,
    output logic                       o_done,
    output logic [BAR_BITS-1:0]        o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_step;
    logic [PROD_BITS-1:0] r_rem;
    logic [PROD_BITS-1:0] r_dsr;
    logic [BAR_BITS-1:0]  r_quot;
    logic                 w_ge;

    assign w_ge   = (r_rem >= r_dsr);
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_BITS'(BAR_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsr  <= PROD_BITS'(i_divisor) << (BAR_BITS - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quot <= {r_quot[BAR_BITS-2:0], w_ge};
            r_dsr  <= r_dsr >> 1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hpb_back.sv]
// Bin engine: holds the bin memory and the running maximum, carries out
// queued commands and holds the result beat. Depends on hpb_pkg and hpb_div.
`default_nettype none

module hpb_back
    import hpb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [BAR_BITS-1:0]   i_bar_scale,
    input  wire logic                  i_cmd_valid,
    input  wire t_cmd                  i_cmd,
    output logic                       o_cmd_pop,
    output t_back_stat                 o_stat,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [31:0]                o_bin_count,
    output logic [7:0]                 o_bar_length,
    output logic [31:0]                o_max_count
);

    typedef enum logic [6:0] {
        ST_CLR  = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_INC  = 7'b0000100,
        ST_RDAT = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    logic [COUNT_BITS-1:0]     r_mem [2**BIN_INDEX_BITS];
    t_state                    r_state;
    t_state                    n_state;
    logic                      r_init;
    logic [BIN_INDEX_BITS-1:0] r_clr_addr;
    logic [BIN_INDEX_BITS-1:0] r_addr;
    logic [COUNT_BITS-1:0]     r_rdata;
    logic [COUNT_BITS-1:0]     r_max;
    logic [COUNT_BITS-1:0]     r_count;
    logic [PROD_BITS-1:0]      r_prod;
    logic [BAR_BITS-1:0]       r_bar;
    logic                      r_out_valid;
    logic [COUNT_BITS-1:0]     r_out_count;
    logic [BAR_BITS-1:0]       r_out_bar;
    logic [COUNT_BITS-1:0]     r_out_max;

    logic                      w_rd_en;
    logic                      w_wr_en;
    logic [BIN_INDEX_BITS-1:0] w_wr_addr;
    logic [COUNT_BITS-1:0]     w_wr_data;
    logic [COUNT_BITS-1:0]     w_inc;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [BAR_BITS-1:0]       w_div_quot;

    assign w_inc = (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;

    always_comb begin
        n_state     = r_state;
        o_cmd_pop   = 1'b0;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_addr;
        w_wr_data   = w_inc;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = '0;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_SAMPLE: begin
                            w_rd_en = 1'b1;
                            n_state = ST_INC;
                        end
                        OP_READ: begin
                            w_rd_en = 1'b1;
                            n_state = ST_RDAT;
                        end
                        default: n_state = ST_CLR;
                    endcase
                end
            end
            ST_INC: begin
                w_wr_en = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RDAT: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_max == '0) begin
                    n_state = ST_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_init      <= 1'b1;
            r_clr_addr  <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_init <= 1'b0;
                end
            end
            if (r_state == ST_IDLE && n_state == ST_CLR) begin
                r_clr_addr <= '0;
                r_max      <= '0;
            end
            if (r_state == ST_INC && w_inc > r_max) begin
                r_max <= w_inc;
            end
            if (r_state == ST_OUT && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_addr <= i_cmd.idx;
        end
        if (r_state == ST_RDAT) begin
            r_count <= r_rdata;
            r_prod  <= PROD_BITS'(i_bar_scale) * PROD_BITS'(r_rdata);
        end
        if (r_state == ST_MUL) begin
            r_bar <= '0;
        end else if (w_div_done) begin
            r_bar <= w_div_quot;
        end
        if (r_state == ST_OUT && !r_out_valid) begin
            r_out_count <= r_count;
            r_out_bar   <= r_bar;
            r_out_max   <= r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[i_cmd.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    hpb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_max),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign o_stat.init  = r_init;
    assign empty        = !r_out_valid;
    assign o_bin_count  = 32'(r_out_count);
    assign o_bar_length = 8'(r_out_bar);
    assign o_max_count  = 32'(r_out_max);

endmodule

`default_nettype wire

[hw/rtl/pixel_histogram_with_bar_scaling.sv]
// Pixel histogram with bar scaling: configuration registers, front end and bin engine.
// Each beat passes through the command queue; a sample then reads its bin and writes it back incremented.
// A read steps through read, multiply, divider start, 8 divider steps, capture and output.
// With a zero maximum a read skips the divider; a clear sweeps the memory one bin a cycle.
// After reset the same sweep runs with full held high.
// Depends on hpb_pkg, hpb_front, hpb_back and hpb_div.
`default_nettype none

module pixel_histogram_with_bar_scaling
    import hpb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_action,
    input  wire logic [23:0] i_sample,
    input  wire logic [15:0] i_bin_index,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_bin_count,
    output logic [7:0]       o_bar_length,
    output logic [31:0]      o_max_count
);

    t_cfg       r_cfg;
    logic       w_cmd_valid;
    t_cmd       w_cmd;
    logic       w_cmd_pop;
    t_back_stat w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format   <= FMT_GRAY8;
            r_cfg.channel_select <= CH_BYTE0;
            r_cfg.bar_scale      <= BAR_SCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PIXEL_FORMAT:   r_cfg.pixel_format   <= i_cfg_data[1:0];
                REG_CHANNEL_SELECT: r_cfg.channel_select <= i_cfg_data[1:0];
                REG_BAR_SCALE:      r_cfg.bar_scale      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hpb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_hold      (w_stat.init),
        .push        (push),
        .full        (full),
        .i_action    (i_action),
        .i_sample    (i_sample),
        .i_bin_index (i_bin_index),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    hpb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bar_scale  (r_cfg.bar_scale),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_stat       (w_stat),
        .empty        (empty),
        .pop          (pop),
        .o_bin_count  (o_bin_count),
        .o_bar_length (o_bar_length),
        .o_max_count  (o_max_count)
    );

    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.init |-> full)
        else $error("Input accepted during the reset clearing pass.");

    a_init_only_from_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$rose(w_stat.init))
        else $error("Reset clearing pass restarted outside reset.");

    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> !$past(w_stat.init))
        else $error("Result beat produced during the reset clearing pass.");

    a_count_within_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_bin_count <= o_max_count))
        else $error("Result bin count exceeds the running maximum.");

endmodule

`default_nettype wire
